// ===== hw/rtl/hbmt_pkg.sv =====
package hbmt_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [15:0] ExpiryReset = 16'd10;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_JOIN_REQ  = 3'd1,
    REQ_HEARTBEAT = 3'd2,
    REQ_JOIN_RSP  = 3'd3,
    REQ_GOSSIP    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_TICK      = 3'd4
  } status_t;

  localparam logic CfgExpiry = 1'b0;
  localparam logic CfgSelfId = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_OUT
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch input item
    logic scan_clr; // start of scan
    logic scan_en;  // examine entry at scan index
    logic rd_hit;   // read memory at hit slot
    logic commit;   // apply update, build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ===== hw/rtl/hbmt_ctrl.sv =====
module hbmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  hbmt_pkg::sts_t sts,
  output hbmt_pkg::cmd_t cmd
);
  import hbmt_pkg::*;

  fsm_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_hit = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/hbmt_datapath.sv =====
module hbmt_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hbmt_pkg::cmd_t            cmd,
  output hbmt_pkg::sts_t            sts,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_wdata,
  input  logic [2:0]                in_req_type,
  input  logic [31:0]               in_member_id,
  input  logic [15:0]               in_member_port,
  input  logic [31:0]               in_member_heartbeat,
  input  logic [31:0]               in_entry_time,
  output logic [2:0]                out_status,
  output logic [5:0]                out_removed_count,
  output logic [5:0]                out_member_count,
  output logic [31:0]               out_own_heartbeat,
  output logic                      out_joined
);
  import hbmt_pkg::*;

  // configuration
  logic [15:0] expiry_r;
  logic [31:0] self_id_r;

  // table storage: ids and stamps scanned, port and heartbeat in memories
  logic [TableDepth-1:0] valid_r;
  logic [31:0] id_mem [TableDepth];
  logic [31:0] stamp_mem [TableDepth];
  logic [15:0] port_mem [TableDepth];
  logic [31:0] hb_mem [TableDepth];

  logic [31:0] time_r, own_hb_r;
  logic        joined_r;

  // latched item
  logic [2:0]  type_r;
  logic [31:0] id_r, hb_r, etime_r;
  logic [15:0] port_r;

  // scan state
  logic [IdxW-1:0] idx_r;
  logic            hit_r, free_ok_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r;
  logic [CntW-1:0] count_r, removed_r;
  logic [31:0]     scan_id_r, scan_stamp_r, hit_hb_r;
  logic            scan_vld_r, scan_on_r;
  logic [IdxW-1:0] scan_at_r;

  // result
  logic [2:0]  status_r;

  logic [31:0] age;
  logic [32:0] gossip_lim;
  logic        stale, is_self, expire;
  logic        refresh_ok;

  assign sts.scan_last = scan_on_r && (scan_at_r == IdxW'(TableDepth - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r  <= ExpiryReset;
      self_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgExpiry: expiry_r  <= cfg_wdata[15:0];
        CfgSelfId: self_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latch item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= in_req_type;
      id_r    <= in_member_id;
      port_r  <= in_member_port;
      hb_r    <= in_member_heartbeat;
      etime_r <= in_entry_time;
    end
  end

  // registered memory reads for the scan pipeline
  always_ff @(posedge clk) begin
    scan_id_r    <= id_mem[idx_r];
    scan_stamp_r <= stamp_mem[idx_r];
    scan_vld_r   <= valid_r[idx_r];
    scan_at_r    <= idx_r;
    hit_hb_r     <= hb_mem[hit_idx_r];
  end

  assign age     = time_r - scan_stamp_r;
  assign expire  = (type_r == REQ_TICK) && joined_r && scan_vld_r && (age > 32'(expiry_r));
  assign gossip_lim = {1'b0, etime_r} + 33'(expiry_r);
  assign stale   = gossip_lim < {1'b0, time_r};
  assign is_self = (id_r == self_id_r);
  // gossip needs a strictly newer heartbeat, direct ones equal or newer
  assign refresh_ok = (type_r == REQ_GOSSIP) ? (hb_r > hit_hb_r) : (hb_r >= hit_hb_r);

  // scan and update; for a tick, time advances as the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      time_r    <= '0;
      own_hb_r  <= '0;
      joined_r  <= 1'b0;
      scan_on_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r     <= '0;
        scan_on_r <= 1'b0;
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
        count_r   <= '0;
        removed_r <= '0;
        if (in_req_type == REQ_TICK) begin
          time_r   <= time_r + 32'd1;
          own_hb_r <= own_hb_r + 32'd1;
        end
        if (in_req_type == REQ_JOIN_RSP) begin
          joined_r <= 1'b1;
        end
      end
      if (cmd.scan_en) begin
        scan_on_r <= 1'b1;
        if (idx_r != IdxW'(TableDepth - 1)) begin
          idx_r <= idx_r + IdxW'(1);
        end
        if (scan_on_r) begin
          if (expire) begin
            valid_r[scan_at_r] <= 1'b0;
            removed_r <= removed_r + CntW'(1);
          end else if (scan_vld_r) begin
            count_r <= count_r + CntW'(1);
          end
          if (scan_vld_r && scan_id_r == id_r && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= scan_at_r;
          end
          if (!scan_vld_r && !free_ok_r) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= scan_at_r;
          end
        end
      end
      if (cmd.commit) begin
        case (type_r)
          REQ_TICK: status_r <= ST_TICK;
          REQ_JOIN_REQ: begin
            if (hit_r) begin
              status_r <= ST_IGNORED;
            end else if (free_ok_r) begin
              valid_r[free_idx_r] <= 1'b1;
              count_r  <= count_r + CntW'(1);
              status_r <= ST_INSERTED;
            end else begin
              status_r <= ST_FULL;
            end
          end
          REQ_HEARTBEAT, REQ_JOIN_RSP, REQ_GOSSIP: begin
            if (is_self || (type_r == REQ_GOSSIP && stale)) begin
              status_r <= ST_IGNORED;
            end else if (!hit_r) begin
              if (free_ok_r) begin
                valid_r[free_idx_r] <= 1'b1;
                count_r  <= count_r + CntW'(1);
                status_r <= ST_INSERTED;
              end else begin
                status_r <= ST_FULL;
              end
            end else if (refresh_ok) begin
              status_r <= ST_REFRESHED;
            end else begin
              status_r <= ST_IGNORED;
            end
          end
          default: status_r <= ST_IGNORED;
        endcase
      end
    end
  end

  // table memory writes at commit; a full table leaves every slot alone
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!hit_r) begin
        if (free_ok_r) begin
          id_mem[free_idx_r]    <= id_r;
          port_mem[free_idx_r]  <= port_r;
          hb_mem[free_idx_r]    <= hb_r;
          stamp_mem[free_idx_r] <= (type_r == REQ_GOSSIP) ? etime_r : time_r;
        end
      end else if (type_r != REQ_JOIN_REQ && type_r != REQ_TICK) begin
        if (refresh_ok) begin
          if (!is_self && !(type_r == REQ_GOSSIP && stale) &&
              (type_r == REQ_HEARTBEAT || type_r == REQ_JOIN_RSP ||
               type_r == REQ_GOSSIP)) begin
            hb_mem[hit_idx_r]    <= hb_r;
            stamp_mem[hit_idx_r] <= time_r;
          end
        end
      end
    end
  end

  assign out_status        = status_r;
  assign out_removed_count = 6'(removed_r);
  assign out_member_count  = 6'(count_r);
  assign out_own_heartbeat = own_hb_r;
  assign out_joined        = joined_r;

endmodule

// ===== hw/rtl/heartbeat_membership_table.sv =====
// Gossip heartbeat membership table of 32 peers. Each item walks the whole
// table once, one entry per cycle through registered reads of the id and
// stamp memories, then reads the matched heartbeat in S_READ and applies
// the update in S_DECIDE; the result is then held in S_OUT until taken.
// One item is in work at a time: the next item is taken only in S_IDLE,
// after the result has been taken. Ticks expire entries during the walk
// once joined; inserts take the lowest free slot. Configuration: index 0
// expiry_ticks, index 1 self_id.
module heartbeat_membership_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_member_id,
  input  logic [15:0] in_member_port,
  input  logic [31:0] in_member_heartbeat,
  input  logic [31:0] in_entry_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_removed_count,
  output logic [5:0]  out_member_count,
  output logic [31:0] out_own_heartbeat,
  output logic        out_joined
);
  import hbmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hbmt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  hbmt_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_wdata,
    .in_req_type, .in_member_id, .in_member_port, .in_member_heartbeat,
    .in_entry_time, .out_status, .out_removed_count, .out_member_count,
    .out_own_heartbeat, .out_joined
  );

  // never ready while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during result");

  // commit always leads to a result next cycle
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("commit without result");

  // only ticks remove entries
  a_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_TICK) |-> out_removed_count == 6'd0)
    else $error("removal outside tick");

endmodule

// ===== tb/membership_checker.sv =====
`timescale 1ns / 100ps

module membership_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_member_id,
  input  logic [15:0] in_member_port,
  input  logic [31:0] in_member_heartbeat,
  input  logic [31:0] in_entry_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [5:0]  out_removed_count,
  input  logic [5:0]  out_member_count,
  input  logic [31:0] out_own_heartbeat,
  input  logic        out_joined,
  output int          fail_count,
  output int          pending
);
  import hbmt_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  removed;
    logic [5:0]  members;
    logic [31:0] own_hb;
    logic        joined;
  } verdict_t;

  // shadow copy of the peer table
  logic        tbl_valid [TableDepth];
  logic [31:0] tbl_id    [TableDepth];
  logic [31:0] tbl_hb    [TableDepth];
  logic [31:0] tbl_stamp [TableDepth];
  logic [31:0] now_ticks;
  logic [31:0] own_hb;
  logic        joined_q;
  logic [15:0] expiry_q;
  logic [31:0] self_q;

  verdict_t expected_verdicts[$];

  function automatic int lookup_peer(logic [31:0] id);
    for (int i = 0; i < TableDepth; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [2:0] add_peer(logic [31:0] id, logic [31:0] hb, logic [31:0] st);
    for (int i = 0; i < TableDepth; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_id[i] = id;
        tbl_hb[i] = hb;
        tbl_stamp[i] = st;
        return ST_INSERTED;
      end
    end
    return ST_FULL;
  endfunction

  function automatic verdict_t apply_item(logic [2:0] kind, logic [31:0] id,
                                          logic [31:0] hb, logic [31:0] et);
    verdict_t v;
    int slot;
    int n;
    logic stale;
    v = '0;
    v.status = ST_IGNORED;
    case (kind)
      REQ_TICK: begin
        now_ticks = now_ticks + 32'd1;
        own_hb = own_hb + 32'd1;
        if (joined_q) begin
          for (int i = 0; i < TableDepth; i++) begin
            if (tbl_valid[i] && (now_ticks - tbl_stamp[i]) > {16'd0, expiry_q}) begin
              tbl_valid[i] = 1'b0;
              v.removed = v.removed + 6'd1;
            end
          end
        end
        v.status = ST_TICK;
      end
      REQ_JOIN_REQ: begin
        if (lookup_peer(id) < 0) v.status = add_peer(id, hb, now_ticks);
      end
      REQ_HEARTBEAT, REQ_JOIN_RSP: begin
        if (kind == REQ_JOIN_RSP) joined_q = 1'b1;
        if (id != self_q) begin
          slot = lookup_peer(id);
          if (slot < 0) v.status = add_peer(id, hb, now_ticks);
          else if (hb >= tbl_hb[slot]) begin
            tbl_hb[slot] = hb;
            tbl_stamp[slot] = now_ticks;
            v.status = ST_REFRESHED;
          end
        end
      end
      REQ_GOSSIP: begin
        stale = ({1'b0, et} + {17'd0, expiry_q}) < {1'b0, now_ticks};
        if (!stale && id != self_q) begin
          slot = lookup_peer(id);
          if (slot < 0) v.status = add_peer(id, hb, et);
          else if (hb > tbl_hb[slot]) begin
            tbl_hb[slot] = hb;
            tbl_stamp[slot] = now_ticks;
            v.status = ST_REFRESHED;
          end
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < TableDepth; i++) if (tbl_valid[i]) n++;
    v.members = n[5:0];
    v.own_hb = own_hb;
    v.joined = joined_q;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
      now_ticks = '0;
      own_hb = '0;
      joined_q = 1'b0;
      expiry_q = ExpiryReset;
      self_q = '0;
      expected_verdicts.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgExpiry) expiry_q = cfg_wdata[15:0];
        else self_q = cfg_wdata;
      end
      // result check against oldest expectation
      if (out_valid && out_ready) begin
        got = {out_status, out_removed_count, out_member_count, out_own_heartbeat,
               out_joined};
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st=%0d rm=%0d mc=%0d hb=%h j=%0d / %s",
                       want.status, want.removed, want.members, want.own_hb,
                       want.joined,
                       $sformatf("got st=%0d rm=%0d mc=%0d hb=%h j=%0d",
                                 got.status, got.removed, got.members, got.own_hb,
                                 got.joined));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_item(in_req_type, in_member_id, in_member_heartbeat, in_entry_time);
        expected_verdicts = {expected_verdicts, want};
      end
      pending = expected_verdicts.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hbmt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [31:0] in_member_id;
  logic [15:0] in_member_port;
  logic [31:0] in_member_heartbeat;
  logic [31:0] in_entry_time;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [5:0]  out_removed_count;
  logic [5:0]  out_member_count;
  logic [31:0] out_own_heartbeat;
  logic        out_joined;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          stall_pct;
  int          hold_off;
  logic        hold_done;
  int          phase_no;
  logic [31:0] model_time;  // rough local time for well-formed gossip
  logic [31:0] peer_ids[48];

  heartbeat_membership_table dut (.*);

  membership_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls plus one long hold-off in stalling phase 2
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (phase_no == 2 && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [2:0] kind, logic [31:0] id, logic [15:0] port,
                           logic [31:0] hb, logic [31:0] et);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_member_id <= id;
    in_member_port <= port;
    in_member_heartbeat <= hb;
    in_entry_time <= et;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
    if (kind == REQ_TICK) model_time = model_time + 1;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_item;
    logic [2:0]  kind;
    logic [31:0] id;
    int          r;
    r = $urandom_range(99);
    id = peer_ids[$urandom_range(47)];
    if ($urandom_range(19) == 0) id = $urandom;
    if (r < 20) kind = REQ_TICK;
    else if (r < 35) kind = REQ_JOIN_REQ;
    else if (r < 60) kind = REQ_HEARTBEAT;
    else if (r < 68) kind = REQ_JOIN_RSP;
    else if (r < 97) kind = REQ_GOSSIP;
    else kind = 3'($urandom_range(7, 5));
    send_item(kind, id, 16'($urandom), ($urandom_range(3) == 0) ? $urandom
              : 32'($urandom_range(20)),
              ($urandom_range(4) == 0) ? $urandom : model_time - $urandom_range(15));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgExpiry;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_member_id = '0;
    in_member_port = '0;
    in_member_heartbeat = '0;
    in_entry_time = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    phase_no = -1;
    model_time = '0;
    for (int i = 0; i < 48; i++) peer_ids[i] = (i < 40) ? 32'(i + 1) : $urandom;
    peer_ids[47] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every request kind, field extremes, self, full table
    send_item(REQ_JOIN_REQ, 32'd0, 16'd0, 32'd0, 32'd0);
    send_item(REQ_HEARTBEAT, 32'd0, 16'hffff, 32'hffff_ffff, 32'd0);
    send_item(REQ_HEARTBEAT, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(REQ_HEARTBEAT, 32'hffff_ffff, 16'd1, 32'd5, 32'd0);
    send_item(REQ_HEARTBEAT, 32'hffff_ffff, 16'd1, 32'hffff_ffff, 32'd0);
    send_item(REQ_GOSSIP, 32'd7, 16'd7, 32'd3, 32'hffff_ffff);
    send_item(REQ_GOSSIP, 32'd7, 16'd7, 32'd3, 32'd0);
    send_item(REQ_GOSSIP, 32'd7, 16'd7, 32'd4, 32'd0);
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(3'd5, '1, '1, '1, '1);
    send_item(3'd7, '1, '1, '1, '1);
    send_item(REQ_JOIN_RSP, 32'd9, 16'd9, 32'd1, 32'd0);
    for (int i = 0; i < 34; i++) send_item(REQ_JOIN_REQ, 32'(100 + i), 16'(i), 32'd1, 32'd0);
    drain();
    cfg_write(CfgExpiry, 32'd0);
    cfg_write(CfgSelfId, 32'd9);
    send_item(REQ_HEARTBEAT, 32'd9, 16'd9, 32'd2, 32'd0);
    send_item(REQ_GOSSIP, 32'd9, 16'd9, 32'd9, model_time);
    send_item(REQ_TICK, '0, '0, '0, '0);
    send_item(REQ_TICK, '0, '0, '0, '0);

    // random phases: idling mixes and configuration settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      case (ph)
        0: cfg_write(CfgExpiry, 32'd10);
        3: cfg_write(CfgExpiry, 32'hffff);
        5: cfg_write(CfgExpiry, 32'd1);
        default: cfg_write(CfgExpiry, 32'($urandom_range(30)));
      endcase
      cfg_write(CfgSelfId, (ph == 6) ? 32'hffff_ffff : peer_ids[$urandom_range(47)]);
      phase_no = ph;
      for (int k = 0; k < 210; k++) random_item();
    end

    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hbmt_pkg.sv
hw/rtl/hbmt_ctrl.sv
hw/rtl/hbmt_datapath.sv
hw/rtl/heartbeat_membership_table.sv
tb/membership_checker.sv
tb/tb_top.sv
